### rtl/w2rgb_pkg.sv
// shared constants, types and elaboration-time functions for the wavelength to rgb core
package w2rgb_pkg;

  // default configuration
  localparam int unsigned IN_FRAC_BITS     = 4;
  localparam int unsigned OUT_BITS         = 8;
  localparam int unsigned GAMMA_TABLE_BITS = 10;

  // input word width
  localparam int unsigned IN_W = 14;

  // q0.16 ratios with room for exactly 1.0
  localparam int unsigned     Q_W   = 17;
  localparam logic [Q_W-1:0] ONE_Q = 17'h10000;

  // ramp ratio: floor((dist << (16 - f)) / band width), numerator stays below 70 * 2^16
  localparam int unsigned RAMP_NUM_W = 23;
  localparam int unsigned RAMP_SHIFT = 30;
  localparam int unsigned RECIP_W    = 26;

  // rounded-up reciprocals, exact for every numerator below 2^23
  localparam logic [RECIP_W-1:0] RECIP_60 =
    RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'd59) / 64'd60);
  localparam logic [RECIP_W-1:0] RECIP_50 =
    RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'd49) / 64'd50);
  localparam logic [RECIP_W-1:0] RECIP_20 =
    RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'd19) / 64'd20);
  localparam logic [RECIP_W-1:0] RECIP_70 =
    RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'd69) / 64'd70);
  localparam logic [RECIP_W-1:0] RECIP_65 =
    RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'd64) / 64'd65);

  // intensity factor: 0.3 + 0.7 * distance / falloff width, distance kept in 1/256 nm
  localparam int unsigned     FACT_Y_FRAC = 8;
  localparam int unsigned     FACT_Y_W    = 15;
  localparam int unsigned     FACT_A_W    = 30;
  localparam int unsigned     FACT_U_W    = 19;
  // 80 nm falloff is 5 * 16 and 40 nm is 5 * 8, on top of the 1/256 nm scale
  localparam int unsigned     FACT_SHIFT_HI = 12;
  localparam int unsigned     FACT_SHIFT_LO = 11;
  localparam logic [15:0]     FACT_SLOPE    = 16'd45875;
  localparam logic [Q_W-1:0]  FACT_BASE     = 17'd19661;

  // divide by five through a rounded-up reciprocal, exact below 2^19
  localparam int unsigned          DIV5_SHIFT = 22;
  localparam int unsigned          DIV5_W     = 20;
  localparam logic [DIV5_W-1:0]    DIV5_RECIP =
    DIV5_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

  // color channels
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // spectral bands, lower edge inclusive
  typedef enum logic [2:0] {
    BAND_VIOLET,  // 380..440
    BAND_BLUE,    // 440..490
    BAND_CYAN,    // 490..510
    BAND_GREEN,   // 510..580
    BAND_YELLOW,  // 580..645
    BAND_RED      // 645..780
  } band_e;

  // reciprocal of the band width in nm
  function automatic logic [RECIP_W-1:0] ramp_recip(band_e band);
    logic [RECIP_W-1:0] recip;
    unique case (band)
      BAND_VIOLET: recip = RECIP_60;
      BAND_BLUE:   recip = RECIP_50;
      BAND_CYAN:   recip = RECIP_20;
      BAND_GREEN:  recip = RECIP_70;
      BAND_YELLOW: recip = RECIP_65;
      default:     recip = '0;
    endcase
    return recip;
  endfunction

  // gamma entry: largest y with (2y-1)^5 * n^4 <= 32 * idx^4 * m^5, exact big integers
  function automatic int unsigned gamma_entry(int unsigned idx, int unsigned gbits,
                                              int unsigned obits);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int unsigned  omax;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int           k;
    int           s;
    omax = (32'd1 << obits) - 32'd1;
    rhs  = 192'd32;
    for (k = 0; k < 4; k++) begin
      rhs = rhs * idx;
    end
    for (k = 0; k < 5; k++) begin
      rhs = rhs * omax;
    end
    lo = 0;
    hi = omax;
    for (s = 0; s < 17; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 32'd1) >> 1;
        lhs = 192'd1;
        for (k = 0; k < 5; k++) begin
          lhs = lhs * (32'd2 * mid - 32'd1);
        end
        lhs = lhs << (4 * gbits);
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 32'd1;
        end
      end
    end
    return lo;
  endfunction

endpackage

### rtl/wavelength_to_rgb_core.sv
// wavelength to rgb core: spectral color approximation pipeline with gamma lookup
// Maps a wavelength (IN_FRAC_BITS fraction bits, clamped to 380..780 nm) to red, green and
// blue intensities of OUT_BITS bits each, using six piecewise-linear spectral bands, an
// intensity falloff toward both ends of the visible range and a power 0.8 gamma curve.
// The datapath is a seven-stage pipeline that takes one request every clock unless a stalled
// output has filled every stage. Every stage holds its own valid bit, so a stalled output
// only backs up as far as the first empty stage and bubbles are squeezed out. The gamma curve
// is a read-only table of 2^GAMMA_TABLE_BITS + 1 entries built at elaboration, held in two
// copies so that the three channels are looked up in the same cycle; no fill pass is
// needed after reset.
module wavelength_to_rgb_core #(
  parameter int unsigned IN_FRAC_BITS     = w2rgb_pkg::IN_FRAC_BITS,
  parameter int unsigned OUT_BITS         = w2rgb_pkg::OUT_BITS,
  parameter int unsigned GAMMA_TABLE_BITS = w2rgb_pkg::GAMMA_TABLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [w2rgb_pkg::IN_W-1:0] wavelength_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OUT_BITS-1:0]      red_o,
  output logic [OUT_BITS-1:0]      green_o,
  output logic [OUT_BITS-1:0]      blue_o
);

  localparam int unsigned STAGES = 7;
  localparam int unsigned Q_W    = w2rgb_pkg::Q_W;
  localparam int unsigned NCH    = w2rgb_pkg::NUM_CH;
  localparam int unsigned NUM_W  = w2rgb_pkg::RAMP_NUM_W;
  localparam int unsigned REC_W  = w2rgb_pkg::RECIP_W;
  localparam int unsigned YW     = w2rgb_pkg::FACT_Y_W;
  localparam int unsigned AW     = w2rgb_pkg::FACT_A_W;
  localparam int unsigned UW     = w2rgb_pkg::FACT_U_W;
  localparam int unsigned D5W    = w2rgb_pkg::DIV5_W;
  localparam int unsigned PW     = 2 * Q_W - 1;

  // clamped wavelength width and band edges in input units
  localparam int unsigned WC = $clog2((780 << IN_FRAC_BITS) + 1);
  localparam int unsigned WX = (WC > w2rgb_pkg::IN_W) ? WC : w2rgb_pkg::IN_W;
  localparam logic [WC-1:0] W380 = WC'(380 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W420 = WC'(420 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W440 = WC'(440 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W490 = WC'(490 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W510 = WC'(510 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W580 = WC'(580 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W645 = WC'(645 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W700 = WC'(700 << IN_FRAC_BITS);
  localparam logic [WC-1:0] W780 = WC'(780 << IN_FRAC_BITS);

  // gamma table geometry; rounding of the product and of the index folded into one add
  localparam int unsigned  GN        = 1 << GAMMA_TABLE_BITS;
  localparam int unsigned  IW        = GAMMA_TABLE_BITS + 1;
  localparam logic [IW-1:0] IDX_MAX  = IW'(GN);
  localparam logic [PW-1:0] ROUND_ADD =
    PW'((64'd1 << 15) + (64'd1 << (31 - GAMMA_TABLE_BITS)));

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] v_d;
  logic [STAGES:0]   adv;

  // a stage moves when it is empty or the stage after it moves
  assign adv[STAGES] = out_ready_i;
  for (genvar gs = 0; gs < STAGES; gs++) begin : g_adv
    assign adv[gs] = ~v_q[gs] | adv[gs+1];
  end

  // valid bits follow the data
  assign v_d[0] = adv[0] ? in_valid_i : v_q[0];
  for (genvar gv = 1; gv < STAGES; gv++) begin : g_valid
    assign v_d[gv] = adv[gv] ? v_q[gv-1] : v_q[gv];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[STAGES-1];

  // ---------------------------------------------------------------------------
  // stage 1: clamp, band select, ramp distance and falloff distance
  // ---------------------------------------------------------------------------
  logic [WX-1:0]        w_ext;
  logic [WC-1:0]        w_clamp;
  logic [WC-1:0]        ramp_dist;
  logic [WC-1:0]        fall_dist;
  w2rgb_pkg::band_e     s1_band_d;
  logic                 s1_hi_d;
  logic                 s1_lo_d;

  always_comb begin
    w_ext = WX'(wavelength_i);
    if (w_ext < WX'(W380)) begin
      w_clamp = W380;
    end else if (w_ext > WX'(W780)) begin
      w_clamp = W780;
    end else begin
      w_clamp = WC'(w_ext);
    end

    if (w_clamp < W440) begin
      s1_band_d = w2rgb_pkg::BAND_VIOLET;
      ramp_dist = W440 - w_clamp;
    end else if (w_clamp < W490) begin
      s1_band_d = w2rgb_pkg::BAND_BLUE;
      ramp_dist = w_clamp - W440;
    end else if (w_clamp < W510) begin
      s1_band_d = w2rgb_pkg::BAND_CYAN;
      ramp_dist = W510 - w_clamp;
    end else if (w_clamp < W580) begin
      s1_band_d = w2rgb_pkg::BAND_GREEN;
      ramp_dist = w_clamp - W510;
    end else if (w_clamp < W645) begin
      s1_band_d = w2rgb_pkg::BAND_YELLOW;
      ramp_dist = W645 - w_clamp;
    end else begin
      s1_band_d = w2rgb_pkg::BAND_RED;
      ramp_dist = '0;
    end

    s1_hi_d   = w_clamp > W700;
    s1_lo_d   = w_clamp < W420;
    fall_dist = s1_hi_d ? (W780 - w_clamp) : (w_clamp - W380);
  end

  w2rgb_pkg::band_e  s1_band_q;
  logic [NUM_W-1:0]  s1_num_q;
  logic              s1_hi_q;
  logic              s1_lo_q;
  logic [YW-1:0]     s1_y_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_band_q <= s1_band_d;
      s1_num_q  <= NUM_W'(ramp_dist) << (16 - IN_FRAC_BITS);
      s1_hi_q   <= s1_hi_d;
      s1_lo_q   <= s1_lo_d;
      s1_y_q    <= YW'(fall_dist) << (w2rgb_pkg::FACT_Y_FRAC - IN_FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: ramp ratio by reciprocal, falloff numerator
  // ---------------------------------------------------------------------------
  logic [NUM_W+REC_W-1:0] ramp_prod;
  logic [AW-1:0]          fact_num;

  always_comb begin
    ramp_prod = {{REC_W{1'b0}}, s1_num_q}
              * {{NUM_W{1'b0}}, w2rgb_pkg::ramp_recip(s1_band_q)};
    fact_num  = AW'(s1_y_q) * AW'(w2rgb_pkg::FACT_SLOPE);
  end

  w2rgb_pkg::band_e  s2_band_q;
  logic [Q_W-1:0]    s2_ratio_q;
  logic              s2_hi_q;
  logic              s2_lo_q;
  logic [AW-1:0]     s2_a_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_band_q  <= s1_band_q;
      s2_ratio_q <= ramp_prod[w2rgb_pkg::RAMP_SHIFT+Q_W-1:w2rgb_pkg::RAMP_SHIFT];
      s2_hi_q    <= s1_hi_q;
      s2_lo_q    <= s1_lo_q;
      s2_a_q     <= fact_num;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: channel ramps per band, falloff divide by five
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0]     s3_ch_d [NCH];
  logic [UW-1:0]      fact_u;
  logic [UW+D5W-1:0]  div5_prod;

  always_comb begin
    s3_ch_d[w2rgb_pkg::CH_RED]   = '0;
    s3_ch_d[w2rgb_pkg::CH_GREEN] = '0;
    s3_ch_d[w2rgb_pkg::CH_BLUE]  = '0;
    unique case (s2_band_q)
      w2rgb_pkg::BAND_VIOLET: begin
        s3_ch_d[w2rgb_pkg::CH_RED]  = s2_ratio_q;
        s3_ch_d[w2rgb_pkg::CH_BLUE] = w2rgb_pkg::ONE_Q;
      end
      w2rgb_pkg::BAND_BLUE: begin
        s3_ch_d[w2rgb_pkg::CH_GREEN] = s2_ratio_q;
        s3_ch_d[w2rgb_pkg::CH_BLUE]  = w2rgb_pkg::ONE_Q;
      end
      w2rgb_pkg::BAND_CYAN: begin
        s3_ch_d[w2rgb_pkg::CH_GREEN] = w2rgb_pkg::ONE_Q;
        s3_ch_d[w2rgb_pkg::CH_BLUE]  = s2_ratio_q;
      end
      w2rgb_pkg::BAND_GREEN: begin
        s3_ch_d[w2rgb_pkg::CH_RED]   = s2_ratio_q;
        s3_ch_d[w2rgb_pkg::CH_GREEN] = w2rgb_pkg::ONE_Q;
      end
      w2rgb_pkg::BAND_YELLOW: begin
        s3_ch_d[w2rgb_pkg::CH_RED]   = w2rgb_pkg::ONE_Q;
        s3_ch_d[w2rgb_pkg::CH_GREEN] = s2_ratio_q;
      end
      w2rgb_pkg::BAND_RED: begin
        s3_ch_d[w2rgb_pkg::CH_RED] = w2rgb_pkg::ONE_Q;
      end
      default: begin
        s3_ch_d[w2rgb_pkg::CH_RED] = '0;
      end
    endcase

    // 80 nm falloff above 700, 40 nm below 420
    fact_u    = s2_hi_q ? UW'(s2_a_q >> w2rgb_pkg::FACT_SHIFT_HI)
                        : UW'(s2_a_q >> w2rgb_pkg::FACT_SHIFT_LO);
    div5_prod = {{D5W{1'b0}}, fact_u} * {{UW{1'b0}}, w2rgb_pkg::DIV5_RECIP};
  end

  logic [Q_W-1:0] s3_ch_q [NCH];
  logic [Q_W-1:0] s3_q_q;
  logic           s3_fall_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_ch_q   <= s3_ch_d;
      s3_q_q    <= div5_prod[w2rgb_pkg::DIV5_SHIFT+Q_W-1:w2rgb_pkg::DIV5_SHIFT];
      s3_fall_q <= s2_hi_q | s2_lo_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: intensity factor
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] s4_ch_q [NCH];
  logic [Q_W-1:0] s4_fact_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_ch_q   <= s3_ch_q;
      s4_fact_q <= s3_fall_q ? (w2rgb_pkg::FACT_BASE + s3_q_q) : w2rgb_pkg::ONE_Q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: channel times factor
  // ---------------------------------------------------------------------------
  logic [2*Q_W-1:0] shade_prod [NCH];
  logic [PW-1:0]    s5_prod_q  [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      shade_prod[c] = {{Q_W{1'b0}}, s4_ch_q[c]} * {{Q_W{1'b0}}, s4_fact_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int c = 0; c < NCH; c++) begin
        s5_prod_q[c] <= shade_prod[c][PW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: round product to q0.16, then to a gamma table index
  // ---------------------------------------------------------------------------
  logic [PW-1:0] idx_sum [NCH];
  logic [IW-1:0] s6_idx_q [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      idx_sum[c] = s5_prod_q[c] + ROUND_ADD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int c = 0; c < NCH; c++) begin
        s6_idx_q[c] <= idx_sum[c][PW-1:PW-IW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: gamma lookup into the output registers
  // ---------------------------------------------------------------------------
  logic [OUT_BITS-1:0] rom_a [GN+1];
  logic [OUT_BITS-1:0] rom_b [GN+1];

  for (genvar gi = 0; gi < GN + 1; gi++) begin : g_rom
    localparam logic [OUT_BITS-1:0] ENTRY =
      OUT_BITS'(w2rgb_pkg::gamma_entry(gi, GAMMA_TABLE_BITS, OUT_BITS));
    assign rom_a[gi] = ENTRY;
    assign rom_b[gi] = ENTRY;
  end

  logic [OUT_BITS-1:0] red_q;
  logic [OUT_BITS-1:0] green_q;
  logic [OUT_BITS-1:0] blue_q;

  // red and green share one table copy, blue reads the other
  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      red_q   <= rom_a[s6_idx_q[w2rgb_pkg::CH_RED]];
      green_q <= rom_a[s6_idx_q[w2rgb_pkg::CH_GREEN]];
      blue_q  <= rom_b[s6_idx_q[w2rgb_pkg::CH_BLUE]];
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef ASSERT_OFF
  // an empty output stage means every stage can move, so a request is always taken
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");

  // ramp ratio never exceeds 1.0
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s2_ratio_q <= w2rgb_pkg::ONE_Q))
    else $error("ramp ratio above one");

  // intensity factor stays within 0.3 .. 1.0
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (s4_fact_q >= w2rgb_pkg::FACT_BASE) && (s4_fact_q <= w2rgb_pkg::ONE_Q))
    else $error("intensity factor out of range");

  // gamma indices stay inside the table
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (s6_idx_q[w2rgb_pkg::CH_RED] <= IDX_MAX)
            && (s6_idx_q[w2rgb_pkg::CH_GREEN] <= IDX_MAX)
            && (s6_idx_q[w2rgb_pkg::CH_BLUE] <= IDX_MAX))
    else $error("gamma index beyond table");
`endif

endmodule

### tb/testbench.sv
// self-checking testbench for the wavelength to rgb core
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IN_W             = w2rgb_pkg::IN_W;
  localparam int unsigned IN_FRAC_BITS     = w2rgb_pkg::IN_FRAC_BITS;
  localparam int unsigned OUT_BITS         = w2rgb_pkg::OUT_BITS;
  localparam int unsigned GAMMA_TABLE_BITS = w2rgb_pkg::GAMMA_TABLE_BITS;

  localparam int unsigned GAMMA_LEN = (1 << GAMMA_TABLE_BITS) + 1;
  localparam int unsigned FULL_OUT  = (1 << OUT_BITS) - 1;
  localparam int unsigned UNIT_Q    = 65536;
  localparam int unsigned DRAIN_CYC = 20;

  typedef struct packed {
    logic [IN_W-1:0]     wavelength;
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } color_t;

  // dut ports, inputs all known from time zero
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [IN_W-1:0]     wavelength_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [OUT_BITS-1:0] red_o;
  logic [OUT_BITS-1:0] green_o;
  logic [OUT_BITS-1:0] blue_o;

  // predicted colors waiting for the core, oldest first
  color_t              colors_due[$];
  logic [OUT_BITS-1:0] gamma_curve[GAMMA_LEN];
  int unsigned         mismatches    = 0;

  // sender burst shaping and receiver stall control
  int unsigned         burst_left    = 0;
  int unsigned         burst_max     = 1;
  int unsigned         gap_max       = 0;
  int unsigned         stall_pct     = 0;
  int unsigned         hold_request  = 0;

  wavelength_to_rgb_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .wavelength_i(wavelength_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("wavelength_to_rgb_core verification failed");
    $finish;
  end

  // y - 0.5 <= M * (idx / N)^0.8, rewritten exactly in integers
  function automatic bit gamma_ok(int unsigned y, int unsigned idx);
    logic [127:0] lhs;
    logic [127:0] rhs;
    int           k;
    if (y == 0) begin
      return 1'b1;
    end
    lhs = 128'd1;
    rhs = 128'd32;
    for (k = 0; k < 5; k++) begin
      lhs = lhs * (2 * y - 1);
      rhs = rhs * FULL_OUT;
    end
    for (k = 0; k < 4; k++) begin
      rhs = rhs * idx;
    end
    lhs = lhs << (4 * GAMMA_TABLE_BITS);
    return lhs <= rhs;
  endfunction

  // the curve is monotonic, so each entry starts its search from the previous one
  function automatic void fill_gamma_curve();
    int unsigned y;
    int unsigned i;
    y = 0;
    for (i = 0; i < GAMMA_LEN; i++) begin
      while (y < FULL_OUT && gamma_ok(y + 1, i)) begin
        y++;
      end
      gamma_curve[i] = OUT_BITS'(y);
    end
  endfunction

  function automatic int unsigned nm(int unsigned x);
    return x << IN_FRAC_BITS;
  endfunction

  // q0.16 ratio of the distance to a band edge over the band width
  function automatic int unsigned band_ratio(int unsigned span, int unsigned width_nm);
    longint unsigned num;
    num = longint'(span) << 16;
    return int'(num / nm(width_nm));
  endfunction

  // intensity factor times channel, then the power curve
  function automatic logic [OUT_BITS-1:0] shade_channel(int unsigned c, int unsigned factor);
    longint unsigned prod;
    longint unsigned idx;
    if (c == 0) begin
      return '0;
    end
    prod = (longint'(c) * factor + 32768) >> 16;
    if (prod > UNIT_Q) begin
      prod = UNIT_Q;
    end
    idx = (prod + (1 << (15 - GAMMA_TABLE_BITS))) >> (16 - GAMMA_TABLE_BITS);
    if (idx > GAMMA_LEN - 1) begin
      idx = GAMMA_LEN - 1;
    end
    return gamma_curve[idx];
  endfunction

  // expected color of one wavelength
  function automatic color_t spectrum_color(logic [IN_W-1:0] wl);
    int unsigned      w;
    int unsigned      r;
    int unsigned      g;
    int unsigned      b;
    int unsigned      factor;
    w2rgb_pkg::band_e band;
    color_t           c;
    w = 32'(wl);
    r = 0;
    g = 0;
    b = 0;
    factor = UNIT_Q;
    if (w < nm(380)) w = nm(380);
    if (w > nm(780)) w = nm(780);
    if (w < nm(440)) band = w2rgb_pkg::BAND_VIOLET;
    else if (w < nm(490)) band = w2rgb_pkg::BAND_BLUE;
    else if (w < nm(510)) band = w2rgb_pkg::BAND_CYAN;
    else if (w < nm(580)) band = w2rgb_pkg::BAND_GREEN;
    else if (w < nm(645)) band = w2rgb_pkg::BAND_YELLOW;
    else band = w2rgb_pkg::BAND_RED;
    case (band)
      w2rgb_pkg::BAND_VIOLET: begin
        r = band_ratio(nm(440) - w, 60);
        b = UNIT_Q;
      end
      w2rgb_pkg::BAND_BLUE: begin
        g = band_ratio(w - nm(440), 50);
        b = UNIT_Q;
      end
      w2rgb_pkg::BAND_CYAN: begin
        g = UNIT_Q;
        b = band_ratio(nm(510) - w, 20);
      end
      w2rgb_pkg::BAND_GREEN: begin
        r = band_ratio(w - nm(510), 70);
        g = UNIT_Q;
      end
      w2rgb_pkg::BAND_YELLOW: begin
        r = UNIT_Q;
        g = band_ratio(nm(645) - w, 65);
      end
      default: begin
        r = UNIT_Q;
      end
    endcase
    // falloff toward both ends of the visible range
    if (w > nm(700)) begin
      factor = 19661 + int'((longint'(45875) * (nm(780) - w)) / nm(80));
    end else if (w < nm(420)) begin
      factor = 19661 + int'((longint'(45875) * (w - nm(380))) / nm(40));
    end
    c.wavelength = wl;
    c.red        = shade_channel(r, factor);
    c.green      = shade_channel(g, factor);
    c.blue       = shade_channel(b, factor);
    return c;
  endfunction

  // send one request, with random gaps between bursts
  task automatic send_wavelength(input logic [IN_W-1:0] wl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(burst_max, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    wavelength_i <= wl;
    do @(posedge clk_i); while (!in_ready_o);
    colors_due.push_back(spectrum_color(wl));
  endtask

  // receiver: runs of ready and stall, or a long hold when asked
  initial begin
    int unsigned hold_cnt;
    int unsigned run_left;
    bit          run_ready;
    hold_cnt  = 0;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_cnt     = hold_request;
        hold_request = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(12, 1);
          run_ready = ($urandom_range(99, 0) >= stall_pct);
        end
        run_left--;
        out_ready_i <= run_ready;
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    color_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (colors_due.size() == 0) begin
        $display("%0t: unexpected result expected none got r=%0d g=%0d b=%0d",
                 $time, red_o, green_o, blue_o);
        mismatches++;
      end else begin
        want = colors_due.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red for wavelength %0d expected %0d got %0d",
                   $time, want.wavelength, want.red, red_o);
          mismatches++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green for wavelength %0d expected %0d got %0d",
                   $time, want.wavelength, want.green, green_o);
          mismatches++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue for wavelength %0d expected %0d got %0d",
                   $time, want.wavelength, want.blue, blue_o);
          mismatches++;
        end
      end
    end
  end

  // every band edge and falloff knee, both sides, plus the field extremes
  task automatic test_band_edges();
    int unsigned edges[9] = '{380, 420, 440, 490, 510, 580, 645, 700, 780};
    int          k;
    gap_max   = 0;
    stall_pct = 0;
    for (k = 0; k < 9; k++) begin
      send_wavelength(IN_W'(nm(edges[k]) - 1));
      send_wavelength(IN_W'(nm(edges[k])));
    end
    send_wavelength('0);
    send_wavelength('1);
    send_wavelength(IN_W'(nm(380) + 1));
    send_wavelength(IN_W'(nm(780) + 1));
    send_wavelength(IN_W'(14'h2aaa));
    send_wavelength(IN_W'(14'h1555));
  endtask

  // whole input range, covers every bit and the clamped regions
  task automatic test_full_range(input int unsigned count);
    gap_max   = 6;
    burst_max = 10;
    stall_pct = 30;
    repeat (count) send_wavelength(IN_W'($urandom_range((1 << IN_W) - 1, 0)));
  endtask

  // inside the visible range only
  task automatic test_visible(input int unsigned count);
    gap_max   = 3;
    burst_max = 20;
    stall_pct = 20;
    repeat (count) send_wavelength(IN_W'($urandom_range(nm(780), nm(380))));
  endtask

  // small offsets around the edges, where ramps are near zero or full
  task automatic test_near_edges(input int unsigned count);
    int unsigned edges[9] = '{380, 420, 440, 490, 510, 580, 645, 700, 780};
    int unsigned base;
    repeat (count) begin
      base = nm(edges[$urandom_range(8, 0)]);
      send_wavelength(IN_W'(base - 40 + $urandom_range(80, 0)));
    end
  endtask

  // full rate in and out
  task automatic test_streaming(input int unsigned count);
    gap_max   = 0;
    stall_pct = 0;
    repeat (count) send_wavelength(IN_W'($urandom_range((1 << IN_W) - 1, 0)));
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    gap_max      = 0;
    stall_pct    = 0;
    hold_request = 80;
    in_valid_i  <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    repeat (40) send_wavelength(IN_W'($urandom_range(nm(780), nm(380))));
  endtask

  // main sequence
  initial begin
    fill_gamma_curve();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_band_edges();
    test_full_range(500);
    test_visible(600);
    test_backpressure();
    test_near_edges(250);
    test_streaming(200);
    test_full_range(100);
    in_valid_i <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("wavelength_to_rgb_core verification clean");
    end else begin
      $display("wavelength_to_rgb_core verification failed");
    end
    $finish;
  end

endmodule
